>>> hdl/u8enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8enc_pkg;

    // Error codes carried with each result.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_PAIR  = 2'd1,
        ERR_LOW   = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    // Unit modes of the configuration register.
    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    // Register byte addresses.
    localparam logic [2:0] ADDR_UNIT_MODE = 3'd0;

    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h01_0000;
    localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;

    // One encode job handed from the front end to the byte serializer.
    // len is the number of UTF-8 bytes minus one.
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  len;
        t_err        err;
        logic        eos;
    } t_item;

    // Number of UTF-8 bytes minus one for a code point up to 0x10FFFF.
    function automatic logic [1:0] utf8_len(input logic [20:0] cp);
        logic [1:0] len;
        if (cp <= 21'h00007F) begin
            len = 2'd0;
        end else if (cp <= 21'h0007FF) begin
            len = 2'd1;
        end else if (cp <= 21'h00FFFF) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 encoding of cp.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] rem;
        rem = len - idx;
        if (idx == 2'd0) begin
            unique case (len)
                2'd0: b = {1'b0, cp[6:0]};
                2'd1: b = {3'b110, cp[10:6]};
                2'd2: b = {4'b1110, cp[15:12]};
                2'd3: b = {5'b11110, cp[20:18]};
                default: b = 8'h00;
            endcase
        end else begin
            unique case (rem)
                2'd0: b = {2'b10, cp[5:0]};
                2'd1: b = {2'b10, cp[11:6]};
                2'd2: b = {2'b10, cp[17:12]};
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/u8enc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8enc_front
    import u8enc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_unit_mode,
    input  wire logic        i_accept,
    input  wire logic [31:0] i_code_unit,
    input  wire logic        i_end_of_string,
    output logic             o_push,
    output t_item            o_item
);

    logic [9:0]  r_pend_bits, n_pend_bits;
    logic        r_pend_valid, n_pend_valid;
    logic        r_dropping, n_dropping;
    logic [15:0] unit16;
    logic        is_high, is_low;
    logic [20:0] cp;
    t_err        err;

    assign unit16  = i_code_unit[15:0];
    assign is_high = (unit16[15:10] == HIGH_SURR_TAG);
    assign is_low  = (unit16[15:10] == LOW_SURR_TAG);

    // Classify the accepted unit and update the surrogate and drop state.
    always_comb begin
        n_pend_bits  = r_pend_bits;
        n_pend_valid = r_pend_valid;
        n_dropping   = r_dropping;
        o_push       = 1'b0;
        cp           = 21'd0;
        err          = ERR_NONE;
        if (i_accept) begin
            priority if (r_dropping) begin
                if (i_end_of_string) begin
                    n_dropping   = 1'b0;
                    n_pend_valid = 1'b0;
                end
            end else if (i_unit_mode == MODE_UTF32) begin
                o_push = 1'b1;
                if (r_pend_valid) begin
                    err = ERR_PAIR;
                end else if (i_code_unit > MAX_CODE_POINT) begin
                    err = ERR_RANGE;
                end else begin
                    cp = i_code_unit[20:0];
                end
            end else if (r_pend_valid) begin
                o_push = 1'b1;
                if (is_low) begin
                    cp           = {1'b0, r_pend_bits, unit16[9:0]} + SUPP_BASE;
                    n_pend_valid = 1'b0;
                end else begin
                    err = ERR_PAIR;
                end
            end else if (is_high) begin
                if (i_end_of_string) begin
                    o_push = 1'b1;
                    err    = ERR_PAIR;
                end else begin
                    n_pend_bits  = unit16[9:0];
                    n_pend_valid = 1'b1;
                end
            end else if (is_low) begin
                o_push = 1'b1;
                err    = ERR_LOW;
            end else begin
                o_push = 1'b1;
                cp     = {5'd0, unit16};
            end

            // Any error clears the held surrogate and drops the rest of the string.
            if (o_push && (err != ERR_NONE)) begin
                n_pend_valid = 1'b0;
                n_dropping   = !i_end_of_string;
            end
        end
    end

    assign o_item.cp  = cp;
    assign o_item.len = utf8_len(cp);
    assign o_item.err = err;
    assign o_item.eos = i_end_of_string;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= 10'd0;
            r_pend_valid <= 1'b0;
            r_dropping   <= 1'b0;
        end else begin
            r_pend_bits  <= n_pend_bits;
            r_pend_valid <= n_pend_valid;
            r_dropping   <= n_dropping;
        end
    end

endmodule

`default_nettype wire

>>> hdl/u8enc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8enc_queue
    import u8enc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/u8enc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8enc_back
    import u8enc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_unit,
    output logic       o_last_of_string,
    output logic [1:0] o_error_code
);

    t_item      r_rec;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last_unit, r_last_str;
    t_err       r_err;

    t_item      cur;
    logic [1:0] cur_idx;
    logic       cur_valid, can_load, step, is_err, done;

    // Work on the held job, or start the job at the queue head.
    assign cur       = r_busy ? r_rec : i_q_item;
    assign cur_idx   = r_busy ? r_idx : 2'd0;
    assign cur_valid = r_busy || !i_q_empty;
    assign can_load  = !r_valid || i_out_ready;
    assign step      = can_load && cur_valid;
    assign o_q_pop   = can_load && !r_busy && !i_q_empty;
    assign is_err    = (cur.err != ERR_NONE);
    assign done      = is_err || (cur_idx == cur.len);

    // Serializer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (step) begin
            r_busy <= !done;
            r_idx  <= cur_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rec <= cur;
        end
    end

    // Output register; takes a new byte whenever it is empty or the current one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte      <= is_err ? 8'h00 : utf8_byte(cur.cp, cur.len, cur_idx);
            r_last_unit <= done;
            r_last_str  <= is_err || (done && cur.eos);
            r_err       <= cur.err;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last_of_unit   = r_last_unit;
    assign o_last_of_string = r_last_str;
    assign o_error_code     = r_err;

endmodule

`default_nettype wire

>>> hdl/utf16_utf32_to_utf8_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-16 / UTF-32 to UTF-8 encoder. Each input transfer carries one code unit, and the
// block emits one UTF-8 byte per output transfer, one to four per code point, or a single
// zero byte with an error code when a surrogate pair is broken, a low surrogate stands
// alone, or a UTF-32 value exceeds 0x10FFFF; after an error the rest of the string is
// discarded up to its end-of-string unit. A front end classifies units and pairs
// surrogates at one unit per cycle while the queue has room and feeds a QUEUE_DEPTH-entry
// queue; a serializer drains it at one byte per cycle, unless the output stalls, into an
// output register. Sustained throughput is therefore set by the output byte rate: a unit
// yields one to four bytes, four for supplementary code points, and a held high surrogate
// yields no output. A unit reaches the output through a queue entry and then the output
// register. The unit_mode register (byte address 0, bit 0) selects UTF-16 (0) or UTF-32
// (1) and should be written only while the block is idle.
module utf16_utf32_to_utf8_encoder_top
    import u8enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Code unit input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_code_unit,
    input  wire logic        i_end_of_string,
    // Byte output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_unit,
    output logic             o_last_of_string,
    output logic [1:0]       o_error_code,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic  r_unit_mode;
    logic  accept, push, q_full, q_empty, q_pop;
    t_item f_item, q_item;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_mode <= MODE_UTF16;
        end else if (psel && penable && pwrite && (paddr == ADDR_UNIT_MODE)) begin
            r_unit_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_UNIT_MODE) ? {31'd0, r_unit_mode} : 32'd0;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    u8enc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_unit_mode     (r_unit_mode),
        .i_accept        (accept),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .o_push          (push),
        .o_item          (f_item)
    );

    u8enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    u8enc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_unit   (o_last_of_unit),
        .o_last_of_string (o_last_of_string),
        .o_error_code     (o_error_code)
    );

endmodule

`default_nettype wire

>>> tb/utf8_byte_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the encoder, works out the UTF-8
// bytes that each accepted code unit must produce and compares them in order with
// the byte transfers that leave the block.
module utf8_byte_checker
    import u8enc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_code_unit,
    input  wire logic        i_end_of_string,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_last_of_unit,
    input  wire logic        i_last_of_string,
    input  wire logic [1:0]  i_error_code,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_bytes_outstanding,
    output int               o_bytes_checked,
    output int               o_error_results
);

    // One expected byte transfer.
    typedef struct {
        logic [7:0] data;
        logic       last_unit;
        logic       last_str;
        t_err       err;
    } t_utf8_byte;

    t_utf8_byte utf8_expected_q[$];

    // Mirror of the register and of the surrogate pairing state.
    logic       unit_mode_q;
    logic [9:0] held_high_bits;
    logic       held_high_valid;
    logic       skipping_string;

    initial begin
        o_fail_count        = 0;
        o_bytes_outstanding = 0;
        o_bytes_checked     = 0;
        o_error_results     = 0;
    end

    // Appends one byte at the tail of the expected stream.
    task automatic queue_expected(input t_utf8_byte e);
        utf8_expected_q.insert(utf8_expected_q.size(), e);
    endtask

    // A single zero byte that carries the error code and closes the string.
    task automatic push_error(input t_err code, input logic eos);
        t_utf8_byte e;
        e.data      = 8'h00;
        e.last_unit = 1'b1;
        e.last_str  = 1'b1;
        e.err       = code;
        queue_expected(e);
        held_high_valid = 1'b0;
        skipping_string = !eos;
    endtask

    // Splits a code point into its UTF-8 byte sequence.
    task automatic push_code_point(input logic [31:0] cp, input logic eos);
        logic [7:0] seq [0:3];
        int         n;
        t_utf8_byte e;
        if (cp <= 32'h7F) begin
            seq[0] = cp[7:0];
            n = 1;
        end else if (cp <= 32'h7FF) begin
            seq[0] = 8'hC0 | cp[10:6];
            seq[1] = 8'h80 | cp[5:0];
            n = 2;
        end else if (cp <= 32'hFFFF) begin
            seq[0] = 8'hE0 | cp[15:12];
            seq[1] = 8'h80 | cp[11:6];
            seq[2] = 8'h80 | cp[5:0];
            n = 3;
        end else if (cp <= 32'h10FFFF) begin
            seq[0] = 8'hF0 | cp[20:18];
            seq[1] = 8'h80 | cp[17:12];
            seq[2] = 8'h80 | cp[11:6];
            seq[3] = 8'h80 | cp[5:0];
            n = 4;
        end else begin
            push_error(ERR_RANGE, eos);
            return;
        end
        for (int k = 0; k < n; k++) begin
            e.data      = seq[k];
            e.last_unit = (k == n - 1);
            e.last_str  = (k == n - 1) && eos;
            e.err       = ERR_NONE;
            queue_expected(e);
        end
    endtask

    // Applies one accepted code unit to the mirrored state.
    task automatic encode_unit(input logic [31:0] unit, input logic eos);
        logic [15:0] u16;
        logic [31:0] cp;
        u16 = unit[15:0];
        if (skipping_string) begin
            if (eos) begin
                skipping_string = 1'b0;
                held_high_valid = 1'b0;
            end
            return;
        end
        if (unit_mode_q == MODE_UTF32) begin
            if (held_high_valid) begin
                push_error(ERR_PAIR, eos);
            end else begin
                push_code_point(unit, eos);
            end
            return;
        end
        if (held_high_valid) begin
            if (u16 >= 16'hDC00 && u16 <= 16'hDFFF) begin
                cp = {12'd0, held_high_bits, u16[9:0]} + 32'h10000;
                held_high_valid = 1'b0;
                push_code_point(cp, eos);
            end else begin
                push_error(ERR_PAIR, eos);
            end
        end else if (u16 >= 16'hD800 && u16 <= 16'hDBFF) begin
            if (eos) begin
                push_error(ERR_PAIR, eos);
            end else begin
                held_high_bits  = u16[9:0];
                held_high_valid = 1'b1;
            end
        end else if (u16 >= 16'hDC00 && u16 <= 16'hDFFF) begin
            push_error(ERR_LOW, eos);
        end else begin
            push_code_point({16'd0, u16}, eos);
        end
    endtask

    // Everything is sampled at the rising edge; outputs are checked before the
    // unit accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (!i_rst_n) begin
            unit_mode_q     = MODE_UTF16;
            held_high_bits  = '0;
            held_high_valid = 1'b0;
            skipping_string = 1'b0;
            utf8_expected_q.delete();
        end else begin
            // Byte transfer out of the block.
            if (i_out_valid === 1'b1 && i_out_ready) begin
                if (utf8_expected_q.size() == 0) begin
                    $display("%0t: unexpected byte transfer: got byte=%02h lu=%0b ls=%0b err=%0d",
                             $time, i_out_byte, i_last_of_unit, i_last_of_string,
                             i_error_code);
                    o_fail_count++;
                end else begin
                    want = utf8_expected_q.pop_front();
                    o_bytes_checked++;
                    if (want.err != ERR_NONE) begin
                        o_error_results++;
                    end
                    if (i_out_byte !== want.data || i_last_of_unit !== want.last_unit ||
                        i_last_of_string !== want.last_str || i_error_code !== want.err) begin
                        $display({"%0t: byte mismatch: expected byte=%02h lu=%0b ls=%0b err=%0d,",
                                  " got byte=%02h lu=%0b ls=%0b err=%0d"},
                                 $time, want.data, want.last_unit, want.last_str, want.err,
                                 i_out_byte, i_last_of_unit, i_last_of_string, i_error_code);
                        o_fail_count++;
                    end
                end
            end

            // Register read-back.
            if (psel && penable && !pwrite && pready && paddr == ADDR_UNIT_MODE) begin
                if (prdata !== {31'd0, unit_mode_q}) begin
                    $display("%0t: unit_mode read mismatch: expected %08h, got %08h",
                             $time, {31'd0, unit_mode_q}, prdata);
                    o_fail_count++;
                end
            end

            // Register write.
            if (psel && penable && pwrite && pready && paddr == ADDR_UNIT_MODE) begin
                unit_mode_q = pwdata[0];
            end

            // Code unit transfer into the block.
            if (i_in_valid && i_in_ready === 1'b1) begin
                encode_unit(i_code_unit, i_end_of_string);
            end
        end
        o_bytes_outstanding = utf8_expected_q.size();
    end

endmodule

>>> tb/tb_utf16_utf32_to_utf8_encoder_top.sv
`timescale 1ns / 1ps

// Drives strings of UTF-16 and UTF-32 code units into the encoder and reports the
// verdict of the byte checker.
module tb_utf16_utf32_to_utf8_encoder_top;
    import u8enc_pkg::*;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_code_unit     = '0;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_unit;
    logic        o_last_of_string;
    logic [1:0]  o_error_code;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int bytes_outstanding;
    int bytes_checked;
    int error_results;
    int units_sent   = 0;
    int strings_sent = 0;
    bit gaps_enabled = 1'b1;

    utf16_utf32_to_utf8_encoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_unit  (o_last_of_unit),
        .o_last_of_string(o_last_of_string),
        .o_error_code    (o_error_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    utf8_byte_checker utf8_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_code_unit        (i_code_unit),
        .i_end_of_string    (i_end_of_string),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_out_byte         (o_out_byte),
        .i_last_of_unit     (o_last_of_unit),
        .i_last_of_string   (o_last_of_string),
        .i_error_code       (o_error_code),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_fail_count       (fail_count),
        .o_bytes_outstanding(bytes_outstanding),
        .o_bytes_checked    (bytes_checked),
        .o_error_results    (error_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("Timeout at %0t with %0d bytes still expected.", $time, bytes_outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The byte receiver stalls at random while gaps are enabled.
    always @(negedge i_clk) begin
        i_out_ready <= !(gaps_enabled && $urandom_range(99) < 11);
    end

    // One code unit transfer; called and returning at a falling edge.
    task automatic send_unit(input logic [31:0] unit, input logic eos);
        while (gaps_enabled && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_code_unit     <= unit;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        units_sent++;
        if (eos) begin
            strings_sent++;
        end
        @(negedge i_clk);
    endtask

    // Waits until every expected byte is out, plus a margin for units that
    // produce no byte but may still be in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (bytes_outstanding != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Writes unit_mode and reads it back in the following transfer.
    task automatic set_unit_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_UNIT_MODE;
        pwdata  <= {31'd0, mode};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] random_bmp_unit();
        int kind;
        kind = $urandom_range(2);
        if (kind == 0) begin
            return 16'($urandom_range(16'h7F));
        end else if (kind == 1) begin
            return 16'($urandom_range(16'h7FF, 16'h80));
        end else if ($urandom_range(1) == 0) begin
            return 16'($urandom_range(16'hD7FF, 16'h800));
        end
        return 16'($urandom_range(16'hFFFF, 16'hE000));
    endfunction

    // Mostly well-formed UTF-16 strings, with broken pairs, stray surrogates and
    // random bits in the unused upper half mixed in.
    task automatic send_string_utf16();
        int          len;
        int          kind;
        logic [15:0] junk;
        logic [19:0] offs;
        logic        eos;
        len = $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
            eos  = (k == len - 1);
            kind = $urandom_range(99);
            junk = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
            if (kind < 68) begin
                send_unit({junk, random_bmp_unit()}, eos);
            end else if (kind < 88) begin
                offs = 20'($urandom_range(20'hFFFFF));
                send_unit({junk, 6'b110110, offs[19:10]}, 1'b0);
                send_unit({16'($urandom), 6'b110111, offs[9:0]}, eos);
            end else if (kind < 92) begin
                send_unit({junk, 6'b110110, 10'($urandom)}, eos);
            end else if (kind < 96) begin
                send_unit({junk, 6'b110111, 10'($urandom)}, eos);
            end else begin
                send_unit($urandom, eos);
            end
        end
    endtask

    // UTF-32 strings: valid code points of every length, surrogate values, the
    // top of the range and values beyond it.
    task automatic send_string_utf32();
        int          len;
        int          kind;
        logic [31:0] cp;
        len = $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                cp = {16'd0, random_bmp_unit()};
            end else if (kind < 75) begin
                cp = $urandom_range(32'h10FFFF, 32'h10000);
            end else if (kind < 85) begin
                cp = $urandom_range(32'hDFFF, 32'hD800);
            end else if (kind < 90) begin
                cp = ($urandom_range(1) == 0) ? 32'h10FFFF : 32'h110000;
            end else begin
                cp = $urandom;
            end
            send_unit(cp, k == len - 1);
        end
    endtask

    initial begin
        int guard;
        guard = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed UTF-16 cases: length boundaries, upper bits ignored, pair extremes,
        // a high surrogate at the end, a broken pair, lone low surrogates, dropping.
        set_unit_mode(MODE_UTF16);
        send_unit(32'h0000_0000, 1'b0);
        send_unit(32'h0000_007F, 1'b0);
        send_unit(32'h0000_0080, 1'b0);
        send_unit(32'h0000_07FF, 1'b0);
        send_unit(32'h0000_0800, 1'b0);
        send_unit(32'hFFFF_FFFF, 1'b1);
        send_unit(32'h0000_D800, 1'b0);
        send_unit(32'h0000_DC00, 1'b0);
        send_unit(32'h0000_DBFF, 1'b0);
        send_unit(32'h0000_DFFF, 1'b1);
        send_unit(32'h0000_D812, 1'b1);
        send_unit(32'h0000_D900, 1'b0);
        send_unit(32'h0000_0041, 1'b0);
        send_unit(32'h0000_0042, 1'b1);
        send_unit(32'h0000_DC05, 1'b0);
        send_unit(32'h0000_0020, 1'b1);
        send_unit(32'h0000_DFFF, 1'b1);
        send_unit(32'h0000_0041, 1'b1);

        // Switch to UTF-32 with a high surrogate still held.
        send_unit(32'h0000_D801, 1'b0);
        wait_idle();
        set_unit_mode(MODE_UTF32);
        send_unit(32'h0000_0041, 1'b0);
        send_unit(32'h0000_0042, 1'b1);

        // Directed UTF-32 cases: range top, out-of-range values, surrogate values.
        send_unit(32'h0010_FFFF, 1'b0);
        send_unit(32'h0011_0000, 1'b0);
        send_unit(32'h0000_0005, 1'b1);
        send_unit(32'hFFFF_FFFF, 1'b1);
        send_unit(32'h0000_D800, 1'b0);
        send_unit(32'h0000_007F, 1'b1);

        // Random phases alternate the mode; the middle phase runs without gaps.
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            gaps_enabled = (phase != 2);
            set_unit_mode((phase % 2 == 0) ? MODE_UTF16 : MODE_UTF32);
            guard = units_sent + 100;
            while (units_sent < guard) begin
                if (phase % 2 == 0) begin
                    send_string_utf16();
                end else begin
                    send_string_utf32();
                end
            end
        end
        gaps_enabled = 1'b1;

        // Let the last bytes drain, with a bound.
        i_in_valid <= 1'b0;
        guard = 0;
        while (bytes_outstanding != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(negedge i_clk);

        $display("Sent %0d code units in %0d strings, in both unit modes and with and without gaps.",
                 units_sent, strings_sent);
        $display("Checked %0d output bytes, %0d of them error results.",
                 bytes_checked, error_results);
        if (fail_count == 0 && bytes_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (bytes_outstanding != 0) begin
                $display("%0t: %0d expected bytes never arrived.", $time, bytes_outstanding);
            end
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
